[src/assert_macros.svh]
// Assertion helpers for the retransmit table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

[src/art_pkg.sv]
`timescale 1ns / 1ps
package art_pkg;
	localparam int SLOTS = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	// command codes
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_FIND = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	// result kinds
	localparam logic [2:0] K_SEND = 3'd0;
	localparam logic [2:0] K_DELIV = 3'd1;
	localparam logic [2:0] K_CANCEL = 3'd2;
	localparam logic [2:0] K_GAVEUP = 3'd3;
	localparam logic [2:0] K_NOTPEND = 3'd4;
	localparam logic [2:0] K_PEND = 3'd5;
	localparam logic [2:0] K_FULL = 3'd6;
	localparam logic [2:0] K_TICKDONE = 3'd7;

	// register addresses
	localparam logic [2:0] ADDR_MAX_TRIES = 3'd0;
	localparam logic [2:0] ADDR_TIMEOUT = 3'd4;

	// one slot entry
	typedef struct packed {
		logic [31:0] id;
		logic [15:0] dest;
		logic [15:0] payload;
		logic [7:0] tries;
		logic forever_f;
		logic notify;
		logic [31:0] sent_at;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] id;
		logic [15:0] dest;
		logic [15:0] payload;
		logic notify;
		logic last;
	} result_t;
endpackage

[src/art_cfg.sv]
`timescale 1ns / 1ps
module art_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [7:0] max_tries_q,
	output logic [15:0] timeout_q
);
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q <= 8'd5;
			timeout_q <= 16'd3;
		end else if (psel && penable && pwrite) begin
			if (paddr == art_pkg::ADDR_MAX_TRIES) max_tries_q <= pwdata[7:0];
			else if (paddr == art_pkg::ADDR_TIMEOUT) timeout_q <= pwdata[15:0];
		end
	end

	// read mux
	always_comb begin
		prdata = 32'd0;
		if (paddr == art_pkg::ADDR_MAX_TRIES) prdata = {24'd0, max_tries_q};
		else if (paddr == art_pkg::ADDR_TIMEOUT) prdata = {16'd0, timeout_q};
	end
endmodule

[src/ack_retransmit_table.sv]
`timescale 1ns / 1ps
// ack_retransmit_table: table of messages waiting for acknowledgement.
// Input stream s_axis: tdata carries msg_id, dest_tag, payload_ref, forever_req,
// notify_wanted, delivered, has_reply_source; tuser carries the command.
// Output stream m_axis: tdata carries msg_id_res, dest_tag_res, payload_ref_res,
// notify_wanted_res; tuser carries the kind; tlast marks the final result of an item.
// APB port: max_tries at 0x0, timeout_ticks at 0x4; pready is always high.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// A single slot pointer walks the table one slot per cycle; during a tick it pauses at
// each overdue entry to emit its results. Add, remove and find scan every slot before
// their single result; a tick emits a resend for each overdue entry, a gave-up result
// for each that gives up, and a final tick-done result.
// Separate compare logic matches ids for remove and find and checks timeouts for ticks.
// If the receiver stalls, the result waits in the output register and the sequencer
// holds before loading the next one. Reset empties the table, zeroes time and the id
// counter, and restores the register defaults.
module ack_retransmit_table (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [31:0] msg_id, [47:32] dest_tag, [63:48] payload_ref, [64] forever_req,
	// [65] notify_wanted, [66] delivered, [67] has_reply_source, rest zero
	input logic [71:0] s_axis_tdata,
	// [1:0] command
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [31:0] msg_id_res, [47:32] dest_tag_res, [63:48] payload_ref_res,
	// [64] notify_wanted_res, rest zero
	output logic [71:0] m_axis_tdata,
	// [2:0] kind
	output logic [2:0] m_axis_tuser,
	output logic m_axis_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int SW = art_pkg::SLOT_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(art_pkg::SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_EMIT = 5'b00100,
		ST_GIVE = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	logic [7:0] max_tries_q;
	logic [15:0] timeout_q;

	art_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .max_tries_q(max_tries_q), .timeout_q(timeout_q)
	);

	state_t state_q;
	logic [art_pkg::SLOTS-1:0] valid_q;
	art_pkg::entry_t slot_q [art_pkg::SLOTS];
	logic [31:0] now_q, next_id_q;
	logic [SW-1:0] ptr_q;
	logic [1:0] cmd_q;
	logic [71:0] req_q;
	logic found_q;
	logic [SW-1:0] hit_q;
	logic out_v_q;
	art_pkg::result_t res_q;

	art_pkg::entry_t cur;
	logic id_match, overdue, out_free, emit_now;
	logic [31:0] age;

	assign cur = slot_q[ptr_q];
	assign age = now_q - cur.sent_at;
	// compare logic: id match for lookups, timeout check for ticks
	assign id_match = valid_q[ptr_q] && (cur.id == req_q[31:0]);
	assign overdue = valid_q[ptr_q] && (age > {16'd0, timeout_q});
	assign out_free = !out_v_q || m_axis_tready;
	// a result is loaded into the output register this cycle
	assign emit_now = out_free && (state_q == ST_EMIT || state_q == ST_GIVE ||
		state_q == ST_DONE);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast = res_q.last;
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tdata = {7'd0, res_q.notify, res_q.payload, res_q.dest, res_q.id};

	function automatic art_pkg::result_t mk(logic [2:0] k, logic [31:0] id,
		logic [15:0] d, logic [15:0] p, logic n, logic l);
		art_pkg::result_t r;
		r.kind = k; r.id = id; r.dest = d; r.payload = p; r.notify = n; r.last = l;
		return r;
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			now_q <= '0;
			next_id_q <= '0;
			ptr_q <= '0;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit_now) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= s_axis_tuser;
						req_q <= s_axis_tdata;
						ptr_q <= '0;
						found_q <= 1'b0;
						if (s_axis_tuser == art_pkg::CMD_TICK) now_q <= now_q + 32'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmd_q == art_pkg::CMD_TICK) begin
						if (overdue) state_q <= ST_EMIT;
						else if (ptr_q == LAST_SLOT) state_q <= ST_DONE;
						else ptr_q <= ptr_q + 1'b1;
					end else begin
						if (!found_q && ((cmd_q == art_pkg::CMD_ADD) ? !valid_q[ptr_q]
							: id_match)) begin
							found_q <= 1'b1;
							hit_q <= ptr_q;
						end
						if (ptr_q == LAST_SLOT) state_q <= ST_DONE;
						else ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_EMIT: begin
					// resend the overdue entry, then update its budget or give it up
					if (out_free) begin
						res_q <= mk(art_pkg::K_SEND, cur.id, cur.dest, cur.payload,
							cur.notify, 1'b0);
						if (!cur.forever_f && cur.tries == 8'd0) begin
							state_q <= ST_GIVE;
						end else begin
							if (!cur.forever_f) slot_q[ptr_q].tries <= cur.tries - 8'd1;
							slot_q[ptr_q].sent_at <= now_q;
							if (ptr_q == LAST_SLOT) state_q <= ST_DONE;
							else begin
								ptr_q <= ptr_q + 1'b1;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_GIVE: begin
					if (out_free) begin
						res_q <= mk(art_pkg::K_GAVEUP, cur.id, cur.dest, cur.payload,
							cur.notify, 1'b0);
						valid_q[ptr_q] <= 1'b0;
						if (ptr_q == LAST_SLOT) state_q <= ST_DONE;
						else begin
							ptr_q <= ptr_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						unique case (cmd_q)
							art_pkg::CMD_ADD: begin
								if (!found_q) begin
									res_q <= mk(art_pkg::K_FULL, '0, '0, '0, 1'b0, 1'b1);
								end else begin
									valid_q[hit_q] <= 1'b1;
									slot_q[hit_q].id <= next_id_q;
									slot_q[hit_q].dest <= req_q[47:32];
									slot_q[hit_q].payload <= req_q[63:48];
									slot_q[hit_q].forever_f <= req_q[64];
									slot_q[hit_q].notify <= req_q[65];
									slot_q[hit_q].tries <= req_q[64] ? 8'd0 :
										((max_tries_q == 8'd0) ? 8'd0 : max_tries_q - 8'd1);
									slot_q[hit_q].sent_at <= now_q;
									next_id_q <= next_id_q + 32'd1;
									res_q <= mk(art_pkg::K_SEND, next_id_q, req_q[47:32],
										req_q[63:48], req_q[65], 1'b1);
								end
							end
							art_pkg::CMD_REMOVE: begin
								if (!found_q) begin
									res_q <= mk(art_pkg::K_NOTPEND, req_q[31:0], '0, '0,
										1'b0, 1'b1);
								end else begin
									valid_q[hit_q] <= 1'b0;
									if (req_q[66])
										res_q <= mk(art_pkg::K_DELIV, req_q[31:0],
											req_q[67] ? req_q[47:32] : slot_q[hit_q].dest,
											req_q[63:48], slot_q[hit_q].notify, 1'b1);
									else
										res_q <= mk(art_pkg::K_CANCEL, req_q[31:0],
											slot_q[hit_q].dest, slot_q[hit_q].payload,
											slot_q[hit_q].notify, 1'b1);
								end
							end
							art_pkg::CMD_FIND: begin
								if (!found_q)
									res_q <= mk(art_pkg::K_NOTPEND, req_q[31:0], '0, '0,
										1'b0, 1'b1);
								else
									res_q <= mk(art_pkg::K_PEND, req_q[31:0],
										slot_q[hit_q].dest, slot_q[hit_q].payload,
										slot_q[hit_q].notify, 1'b1);
							end
							default: res_q <= mk(art_pkg::K_TICKDONE, '0, '0, '0,
								1'b0, 1'b1);
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	// a waiting result holds while the receiver stalls
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// no input taken while a scan is in progress
	`ASSERT_IMPL(a_busy, clk, arst_n, state_q != ST_IDLE, !s_axis_tready)
	// gave-up step is only reached for an exhausted bounded entry
	`ASSERT_IMPL(a_give, clk, arst_n, state_q == ST_GIVE,
		valid_q[ptr_q] && !cur.forever_f && cur.tries == 8'd0)
endmodule

[tb/sv/tb_ack_retransmit_table.sv]
`timescale 1ns / 1ps
module tb_ack_retransmit_table;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ack_retransmit_table i_dut (.*);

	always #5 clk = ~clk;

	// one command item as queued for the driver
	typedef struct {
		logic [1:0] cmd;
		logic [71:0] data;
	} cmd_item_t;

	// table model
	logic [7:0] cfg_tries;
	logic [15:0] cfg_timeout;
	logic tbl_valid [art_pkg::SLOTS];
	art_pkg::entry_t tbl [art_pkg::SLOTS];
	logic [31:0] now_tk;
	logic [31:0] id_ctr;

	cmd_item_t pending_cmds[$];
	art_pkg::result_t awaited_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit tx_hold = 1'b0;
	logic in_fire = 1'b0;

	function automatic logic [71:0] pack_cmd(logic [31:0] id, logic [15:0] dest,
			logic [15:0] pay, logic fv, logic nt, logic dl, logic rs);
		return {4'b0, rs, dl, nt, fv, pay, dest, id};
	endfunction

	function automatic void push_res(logic [2:0] k, logic [31:0] id, logic [15:0] d,
			logic [15:0] p, logic n);
		art_pkg::result_t r;
		r.kind = k; r.id = id; r.dest = d; r.payload = p; r.notify = n; r.last = 1'b0;
		awaited_results = {awaited_results, r};
	endfunction

	function automatic int find_slot(logic [31:0] id);
		for (int i = 0; i < art_pkg::SLOTS; i++)
			if (tbl_valid[i] && tbl[i].id == id) return i;
		return -1;
	endfunction

	// compute expected results of one accepted item and update the table model
	function automatic void predict_table(cmd_item_t it);
		logic [31:0] id;
		logic [15:0] dest, pay;
		logic fv, nt, dl, rs;
		int s;
		id = it.data[31:0]; dest = it.data[47:32]; pay = it.data[63:48];
		fv = it.data[64]; nt = it.data[65]; dl = it.data[66]; rs = it.data[67];
		s = -1;
		case (it.cmd)
			art_pkg::CMD_ADD: begin
				for (int i = art_pkg::SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
				if (s < 0) begin
					push_res(art_pkg::K_FULL, '0, '0, '0, 1'b0);
				end else begin
					tbl_valid[s] = 1'b1;
					tbl[s].id = id_ctr;
					tbl[s].dest = dest;
					tbl[s].payload = pay;
					tbl[s].forever_f = fv;
					tbl[s].notify = nt;
					tbl[s].tries = fv ? 8'd0 : (cfg_tries == 8'd0 ? 8'd0 : cfg_tries - 8'd1);
					tbl[s].sent_at = now_tk;
					push_res(art_pkg::K_SEND, id_ctr, dest, pay, nt);
					id_ctr++;
				end
			end
			art_pkg::CMD_REMOVE: begin
				s = find_slot(id);
				if (s < 0) push_res(art_pkg::K_NOTPEND, id, '0, '0, 1'b0);
				else begin
					if (dl) push_res(art_pkg::K_DELIV, id, rs ? dest : tbl[s].dest, pay,
						tbl[s].notify);
					else push_res(art_pkg::K_CANCEL, id, tbl[s].dest, tbl[s].payload,
						tbl[s].notify);
					tbl_valid[s] = 1'b0;
				end
			end
			art_pkg::CMD_FIND: begin
				s = find_slot(id);
				if (s < 0) push_res(art_pkg::K_NOTPEND, id, '0, '0, 1'b0);
				else push_res(art_pkg::K_PEND, id, tbl[s].dest, tbl[s].payload,
					tbl[s].notify);
			end
			default: begin
				now_tk++;
				for (int i = 0; i < art_pkg::SLOTS; i++) begin
					if (!tbl_valid[i] || (now_tk - tbl[i].sent_at) <= {16'd0, cfg_timeout})
						continue;
					push_res(art_pkg::K_SEND, tbl[i].id, tbl[i].dest, tbl[i].payload,
						tbl[i].notify);
					if (tbl[i].forever_f) tbl[i].sent_at = now_tk;
					else if (tbl[i].tries == 8'd0) begin
						push_res(art_pkg::K_GAVEUP, tbl[i].id, tbl[i].dest, tbl[i].payload,
							tbl[i].notify);
						tbl_valid[i] = 1'b0;
					end else begin
						tbl[i].tries--;
						tbl[i].sent_at = now_tk;
					end
				end
				push_res(art_pkg::K_TICKDONE, '0, '0, '0, 1'b0);
			end
		endcase
		awaited_results[$].last = 1'b1;
	endfunction

	// input acceptance seen at the last rising edge
	always @(posedge clk) in_fire <= s_axis_tvalid && s_axis_tready;

	// driver: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_cmds.size() > 0 && !tx_hold) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= pending_cmds[0].cmd;
					s_axis_tdata <= pending_cmds[0].data;
					void'(pending_cmds.pop_front());
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern: phases of full speed and phases of random stalls
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase = (stall_phase + 1) % 64;
		if (stall_phase < 20) m_axis_tready <= 1'b1;
		else if (stall_phase < 40) m_axis_tready <= ($urandom_range(0, 3) != 0);
		else m_axis_tready <= ($urandom_range(0, 1) == 1);
	end

	// monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		art_pkg::result_t exp_r;
		cmd_item_t acc;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				acc.cmd = s_axis_tuser;
				acc.data = s_axis_tdata;
				predict_table(acc);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result kind=%0d id=%0h", m_axis_tuser,
						m_axis_tdata[31:0]);
					errors++;
				end else begin
					exp_r = awaited_results.pop_front();
					if (m_axis_tuser !== exp_r.kind) begin
						$error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[31:0] !== exp_r.id) begin
						$error("msg_id_res: expected %0h, got %0h", exp_r.id,
							m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tdata[47:32] !== exp_r.dest) begin
						$error("dest_tag_res: expected %0h, got %0h", exp_r.dest,
							m_axis_tdata[47:32]);
						errors++;
					end
					if (m_axis_tdata[63:48] !== exp_r.payload) begin
						$error("payload_ref_res: expected %0h, got %0h", exp_r.payload,
							m_axis_tdata[63:48]);
						errors++;
					end
					if (m_axis_tdata[64] !== exp_r.notify) begin
						$error("notify_wanted_res: expected %0b, got %0b", exp_r.notify,
							m_axis_tdata[64]);
						errors++;
					end
					if (m_axis_tlast !== exp_r.last) begin
						$error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("ack_retransmit_table test failed");
				$finish;
			end
		end
	end

	// APB register write, both model and block
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == art_pkg::ADDR_MAX_TRIES) cfg_tries = value[7:0];
		else cfg_timeout = value[15:0];
	endtask

	task automatic queue_cmd(logic [1:0] cmd, logic [71:0] data);
		cmd_item_t it;
		it.cmd = cmd;
		it.data = data;
		pending_cmds = {pending_cmds, it};
	endtask

	// wait until every queued item is accepted and every result has come
	task automatic drain_all();
		while (pending_cmds.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// random item, mostly adds and ticks with removes/finds of live-ish ids
	function automatic cmd_item_t rand_cmd();
		cmd_item_t it;
		logic [31:0] id;
		int sel;
		sel = $urandom_range(0, 99);
		id = (id_ctr > 20 && $urandom_range(0, 9) != 0) ?
			id_ctr - $urandom_range(1, 20) : $urandom_range(0, 40);
		if ($urandom_range(0, 30) == 0) id = $urandom;
		it.data = pack_cmd(id, 16'($urandom), 16'($urandom), $urandom_range(0, 5) == 0,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		if (sel < 30) it.cmd = art_pkg::CMD_ADD;
		else if (sel < 50) it.cmd = art_pkg::CMD_REMOVE;
		else if (sel < 65) it.cmd = art_pkg::CMD_FIND;
		else it.cmd = art_pkg::CMD_TICK;
		return it;
	endfunction

	initial begin
		cmd_item_t it;
		cfg_tries = 8'd5;
		cfg_timeout = 16'd3;
		for (int i = 0; i < art_pkg::SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl[i] = '0;
		end
		now_tk = '0;
		id_ctr = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: defaults, extremes of fields, every command
		queue_cmd(art_pkg::CMD_FIND, pack_cmd(32'hFFFF_FFFF, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1));
		queue_cmd(art_pkg::CMD_REMOVE, pack_cmd(32'd0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_cmd(art_pkg::CMD_ADD,
			pack_cmd(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1));
		queue_cmd(art_pkg::CMD_ADD,
			pack_cmd(32'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
		queue_cmd(art_pkg::CMD_ADD,
			pack_cmd(32'd0, 16'h1234, 16'hABCD, 1'b0, 1'b1, 1'b0, 1'b0));
		queue_cmd(art_pkg::CMD_FIND, pack_cmd(32'd1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_cmd(art_pkg::CMD_REMOVE,
			pack_cmd(32'd2, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b1, 1'b1));
		queue_cmd(art_pkg::CMD_ADD,
			pack_cmd(32'd0, 16'h00F0, 16'h0F00, 1'b0, 1'b0, 1'b0, 1'b0));
		queue_cmd(art_pkg::CMD_REMOVE,
			pack_cmd(32'd3, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b1, 1'b0));
		for (int k = 0; k < 12; k++)
			queue_cmd(art_pkg::CMD_TICK,
				pack_cmd(32'hFFFF_FFFF, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1));
		queue_cmd(art_pkg::CMD_REMOVE, pack_cmd(32'd1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
		drain_all();

		// fill the table to overflow with a tight timeout and single try
		write_reg(art_pkg::ADDR_MAX_TRIES, 32'd1);
		write_reg(art_pkg::ADDR_TIMEOUT, 32'd1);
		for (int k = 0; k < art_pkg::SLOTS + 2; k++)
			queue_cmd(art_pkg::CMD_ADD, pack_cmd($urandom, 16'($urandom), 16'($urandom),
				1'b0, 1'b1, 1'b0, 1'b0));
		for (int k = 0; k < 4; k++) queue_cmd(art_pkg::CMD_TICK, '0);
		drain_all();

		// random phases over several settings, extremes included
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(art_pkg::ADDR_MAX_TRIES, 32'd255);
					write_reg(art_pkg::ADDR_TIMEOUT, 32'd65535);
				end
				1: begin
					write_reg(art_pkg::ADDR_MAX_TRIES, 32'd0);
					write_reg(art_pkg::ADDR_TIMEOUT, 32'd2);
				end
				2: begin
					write_reg(art_pkg::ADDR_MAX_TRIES, 32'd3);
					write_reg(art_pkg::ADDR_TIMEOUT, 32'd1);
				end
				default: begin
					write_reg(art_pkg::ADDR_MAX_TRIES, $urandom_range(1, 255));
					write_reg(art_pkg::ADDR_TIMEOUT, $urandom_range(1, 6));
				end
			endcase
			for (int k = 0; k < 85; k++) begin
				// sender holds off with items pending until all results are in
				if (ph == 1 && k == 42) begin
					while (pending_cmds.size() > 0) @(posedge clk);
					tx_hold = 1'b1;
				end
				it = rand_cmd();
				pending_cmds = {pending_cmds, it};
			end
			if (tx_hold) begin
				while (s_axis_tvalid || awaited_results.size() > 0) @(posedge clk);
				tx_hold = 1'b0;
			end
			drain_all();
		end

		if (errors == 0) begin
			$display("ack_retransmit_table test passed");
		end else begin
			$display("ack_retransmit_table test failed");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/art_pkg.sv
src/art_cfg.sv
src/ack_retransmit_table.sv
tb/sv/tb_ack_retransmit_table.sv
